/* sv/olist_pkg.sv */
// olist_pkg: shared constants, enums and structs for the ordered list engine
// no dependencies; imported by every module of the block except olist_ram
package olist_pkg;

    localparam int LIST_DEPTH  = 1024;
    localparam int ADDR_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int POS_W       = 11;
    localparam int IDX_W       = 10;
    localparam int FILL_W      = 11;
    localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_ALTER  = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SEARCH,
        S_POP
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic                     pos_zero;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         ins_addr;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] new_value;
    } t_cmd;

    typedef struct packed {
        t_status                  status;
        logic [IDX_W-1:0]         found_index;
        logic signed [DATA_W-1:0] data_out;
        logic [FILL_W-1:0]        fill_count;
    } t_result;

endpackage

/* sv/olist_ram.sv */
// olist_ram: generic simple dual-port memory, one write and one registered read
// no dependencies
module olist_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int AWIDTH = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AWIDTH-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [AWIDTH-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/olist_front.sv */
// olist_front: accepts request beats, decodes them into commands and queues them
// depends on olist_pkg
module olist_front
    import olist_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_req_type,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_new_value,
    output t_cmd                     o_cmd,
    output logic                     o_cmd_valid,
    input  logic                     i_cmd_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_qcnt;
    t_cmd              cmd_in;
    logic              push;
    logic              pop;

    // decode the request
    always_comb begin
        cmd_in.op        = t_op'(i_req_type);
        cmd_in.pos_zero  = (i_position == '0);
        cmd_in.position  = i_position;
        cmd_in.ins_addr  = i_position - 1'b1;
        cmd_in.value     = i_value;
        cmd_in.new_value = i_new_value;
    end

    assign o_ready     = (r_qcnt != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_qcnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_qcnt   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (pop && !push) begin
                r_qcnt <= r_qcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

/* sv/olist_back.sv */
// olist_back: carries out queued commands against the element memory
// depends on olist_pkg and olist_ram
module olist_back
    import olist_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_pop,
    output t_result o_res,
    output logic    o_res_valid,
    input  logic    i_res_ready
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [CNT_W-1:0]         r_ins, n_ins;
    logic                     r_pend, n_pend;
    logic [ADDR_W-1:0]        r_pend_addr, n_pend_addr;
    logic                     r_cmp_vld, n_cmp_vld;
    logic [ADDR_W-1:0]        r_cmp_idx, n_cmp_idx;
    t_op                      r_op, n_op;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic signed [DATA_W-1:0] r_new_value, n_new_value;
    t_result                  r_res, n_res;
    logic                     r_res_valid, n_res_valid;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic             out_free;
    logic             start;
    logic             ins_bad;
    logic             ins_full;
    logic             cnt_zero;
    logic             shift_done;
    logic             search_issue;
    logic             match;
    logic             res_load;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_p1;

    assign out_free     = !r_res_valid || i_res_ready;
    assign start        = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign ins_bad      = i_cmd.pos_zero ||
                          (CMP_W'(i_cmd.position) > (CMP_W'(r_count) + CMP_W'(1)));
    assign ins_full     = (r_count == CNT_W'(LIST_DEPTH));
    assign cnt_zero     = (r_count == '0);
    assign shift_done   = (r_idx == r_ins);
    assign search_issue = (r_idx < r_count);
    assign match        = r_cmp_vld && (rd_data == r_value);
    assign idx_m1       = r_idx - 1'b1;
    assign cnt_m1       = r_count - 1'b1;
    assign cnt_p1       = r_count + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        OP_INSERT: begin
                            if (!ins_bad && !ins_full) begin
                                n_state = S_SHIFT;
                            end
                        end
                        OP_FIND, OP_ALTER: begin
                            n_state = S_SEARCH;
                        end
                        OP_POP: begin
                            if (!cnt_zero) begin
                                n_state = S_POP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SHIFT: begin
                if (shift_done && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (match || !search_issue) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_ins       = r_ins;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_op        = r_op;
        n_value     = r_value;
        n_new_value = r_new_value;
        n_res       = r_res;
        res_load    = 1'b0;
        o_cmd_pop   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        n_res.status      = ST_OK;
        n_res.found_index = '0;
        n_res.data_out    = '0;
        n_res.fill_count  = FILL_W'(r_count);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd_pop   = 1'b1;
                    n_op        = i_cmd.op;
                    n_value     = i_cmd.value;
                    n_new_value = i_cmd.new_value;
                    n_pend      = 1'b0;
                    n_cmp_vld   = 1'b0;
                    unique case (i_cmd.op)
                        OP_INSERT: begin
                            if (ins_bad) begin
                                res_load     = 1'b1;
                                n_res.status = ST_MISS;
                            end else if (ins_full) begin
                                res_load     = 1'b1;
                                n_res.status = ST_FULL;
                            end else begin
                                n_idx = r_count;
                                n_ins = CNT_W'(i_cmd.ins_addr);
                            end
                        end
                        OP_FIND, OP_ALTER: begin
                            n_idx = '0;
                        end
                        OP_POP: begin
                            if (cnt_zero) begin
                                res_load     = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = cnt_m1[ADDR_W-1:0];
                            end
                        end
                        default: res_load = 1'b0;
                    endcase
                end
            end
            S_SHIFT: begin
                // move one entry up per cycle, read and write overlapped
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_addr;
                    wr_data = rd_data;
                end
                if (!shift_done) begin
                    rd_en       = 1'b1;
                    rd_addr     = idx_m1[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx[ADDR_W-1:0];
                    n_idx       = idx_m1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        wr_en            = 1'b1;
                        wr_addr          = r_ins[ADDR_W-1:0];
                        wr_data          = r_value;
                        n_count          = cnt_p1;
                        res_load         = 1'b1;
                        n_res.fill_count = FILL_W'(cnt_p1);
                    end
                end
            end
            S_SEARCH: begin
                if (match) begin
                    res_load          = 1'b1;
                    n_res.found_index = IDX_W'(r_cmp_idx);
                    if (r_op == OP_ALTER) begin
                        wr_en   = 1'b1;
                        wr_addr = r_cmp_idx;
                        wr_data = r_new_value;
                    end
                end else if (search_issue) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_idx[ADDR_W-1:0];
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[ADDR_W-1:0];
                    n_idx     = r_idx + 1'b1;
                end else begin
                    res_load     = 1'b1;
                    n_res.status = ST_MISS;
                end
            end
            S_POP: begin
                n_count          = cnt_m1;
                res_load         = 1'b1;
                n_res.data_out   = rd_data;
                n_res.fill_count = FILL_W'(cnt_m1);
            end
            default: res_load = 1'b0;
        endcase

        if (!res_load) begin
            n_res = r_res;
        end

        n_res_valid = r_res_valid;
        if (res_load) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_cmp_vld   <= n_cmp_vld;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_ins       <= n_ins;
        r_pend_addr <= n_pend_addr;
        r_cmp_idx   <= n_cmp_idx;
        r_op        <= n_op;
        r_value     <= n_value;
        r_new_value <= n_new_value;
        r_res       <= n_res;
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    olist_ram #(
        .DEPTH  (LIST_DEPTH),
        .WIDTH  (DATA_W),
        .AWIDTH (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

/* sv/ordered_list_engine.sv */
// ordered_list_engine: fixed-capacity ordered list of signed 32-bit words
// insert shifts the entries above the position up and then writes; find and alter walk from index 0
// one request runs in the back end at a time; single-port read walk of the element memory
// sets the rate, so no new command is taken until the last one is done
// a two-entry command queue keeps accepting beats while a result waits on the output
// reset clears the count and the queues; the element memory is not cleared
module ordered_list_engine
    import olist_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_req_type,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_new_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic [IDX_W-1:0]         o_found_index,
    output logic signed [DATA_W-1:0] o_data_out,
    output logic [FILL_W-1:0]        o_fill_count
);

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    t_result res;

    olist_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_new_value (i_new_value),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    olist_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready)
    );

    assign o_status      = res.status;
    assign o_found_index = res.found_index;
    assign o_data_out    = res.data_out;
    assign o_fill_count  = res.fill_count;

endmodule

/* tb/sv/list_result_checker.sv */
`timescale 1ns / 1ps
// list_result_checker: watches both channels of ordered_list_engine and checks its results
// keeps its own copy of the list to predict each result; depends on olist_pkg
module list_result_checker
    import olist_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  logic [1:0]               i_req_type,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_new_value,
    input  logic                     i_rsp_valid,
    input  logic                     i_rsp_ready,
    input  logic [1:0]               i_status,
    input  logic [IDX_W-1:0]         i_found_index,
    input  logic signed [DATA_W-1:0] i_data_out,
    input  logic [FILL_W-1:0]        i_fill_count,
    output int                       o_mismatches,
    output int                       o_pending
);

    logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
    int                       shadow_len = 0;
    t_result                  expected_results [$];
    int                       mismatch_cnt = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: result %s mismatch, got %h expected %h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic t_result apply_list_request(input t_op op, input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val,
                                                   input logic signed [DATA_W-1:0] nval);
        t_result r;
        int      hit;
        r.status      = ST_OK;
        r.found_index = '0;
        r.data_out    = '0;
        hit           = -1;
        if (op == OP_FIND || op == OP_ALTER) begin
            for (int i = 0; i < shadow_len && hit < 0; i++) begin
                if (shadow_list[i] == val) hit = i;
            end
        end
        case (op)
            OP_INSERT: begin
                if (pos < 1 || int'(pos) > shadow_len + 1) begin
                    r.status = ST_MISS;
                end else if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_len; i >= int'(pos); i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos-1] = val;
                    shadow_len++;
                end
            end
            OP_FIND, OP_ALTER: begin
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.found_index = hit[IDX_W-1:0];
                    if (op == OP_ALTER) shadow_list[hit] = nval;
                end
            end
            default: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_len--;
                    r.data_out = shadow_list[shadow_len];
                end
            end
        endcase
        r.fill_count = shadow_len[FILL_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            shadow_len = 0;
            expected_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("beat with nothing pending", {30'd0, i_status}, 32'd0);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (i_status != want.status)
                        report_mismatch("status", {30'd0, i_status}, {30'd0, want.status});
                    if (i_found_index != want.found_index)
                        report_mismatch("found_index", {22'd0, i_found_index},
                                        {22'd0, want.found_index});
                    if (i_data_out != want.data_out)
                        report_mismatch("data_out", i_data_out, want.data_out);
                    if (i_fill_count != want.fill_count)
                        report_mismatch("fill_count", {21'd0, i_fill_count},
                                        {21'd0, want.fill_count});
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.insert(expected_results.size(),
                                        apply_list_request(t_op'(i_req_type), i_position,
                                                           i_value, i_new_value));
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_results.size();
    end

endmodule

/* tb/sv/tb_ordered_list_engine.sv */
`timescale 1ns / 1ps
// tb_ordered_list_engine: stimulus, handshake pacing and verdict for ordered_list_engine
// depends on olist_pkg, ordered_list_engine and list_result_checker
module tb_ordered_list_engine;
    import olist_pkg::*;

    localparam int STALL_LIMIT = 8000;
    localparam int DRAIN_CYCLES = 1100;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     tx_valid = 1'b0;
    logic [1:0]               tx_op = OP_INSERT;
    logic [POS_W-1:0]         tx_pos = '0;
    logic signed [DATA_W-1:0] tx_value = '0;
    logic signed [DATA_W-1:0] tx_new_value = '0;
    logic                     rx_ready = 1'b0;
    int                       rx_wait = 0;
    logic                     no_idle = 1'b0;

    logic                     o_ready;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic [IDX_W-1:0]         o_found_index;
    logic signed [DATA_W-1:0] o_data_out;
    logic [FILL_W-1:0]        o_fill_count;

    int                       mismatches;
    int                       pending;
    int                       idle_cycles = 0;
    int                       list_len = 0;
    logic signed [DATA_W-1:0] val_pool [16];

    always #2 i_clk = ~i_clk;

    ordered_list_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (tx_valid),
        .o_ready      (o_ready),
        .i_req_type   (tx_op),
        .i_position   (tx_pos),
        .i_value      (tx_value),
        .i_new_value  (tx_new_value),
        .o_valid      (o_valid),
        .i_ready      (rx_ready),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_data_out   (o_data_out),
        .o_fill_count (o_fill_count)
    );

    list_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (tx_valid),
        .i_req_ready  (o_ready),
        .i_req_type   (tx_op),
        .i_position   (tx_pos),
        .i_value      (tx_value),
        .i_new_value  (tx_new_value),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (rx_ready),
        .i_status     (o_status),
        .i_found_index(o_found_index),
        .i_data_out   (o_data_out),
        .i_fill_count (o_fill_count),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin : result_pacing
        int w;
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            rx_wait  <= 0;
        end else if (rx_ready && o_valid) begin
            w = no_idle ? 0 : $urandom_range(0, 12);
            rx_wait  <= w;
            rx_ready <= (w == 0);
        end else if (!rx_ready) begin
            if (rx_wait <= 1) begin
                rx_ready <= 1'b1;
                rx_wait  <= 0;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tx_valid && o_ready) || (o_valid && rx_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_ordered_list_engine failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_req(input t_op op, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val,
                            input logic signed [DATA_W-1:0] nval);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tx_valid     <= 1'b1;
        tx_op        <= op;
        tx_pos       <= pos;
        tx_value     <= val;
        tx_new_value <= nval;
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_INSERT && pos >= 1 && int'(pos) <= list_len + 1 && list_len < LIST_DEPTH)
            list_len++;
        else if (op == OP_POP && list_len > 0)
            list_len--;
    endtask

    task automatic wait_results_drained();
        tx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return val_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    task automatic random_items(input int n);
        int sel;
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) no_idle <= ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (list_len > 48 && sel < 40)
                send_req(OP_POP, POS_W'($urandom), $urandom, $urandom);
            else if (sel < 40)
                send_req(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value(),
                         $urandom);
            else if (sel < 48)
                send_req(OP_INSERT, POS_W'($urandom_range(0, 2047)), pick_value(), $urandom);
            else if (sel < 65)
                send_req(OP_FIND, POS_W'($urandom), pick_value(), $urandom);
            else if (sel < 80)
                send_req(OP_ALTER, POS_W'($urandom), pick_value(), pick_value());
            else
                send_req(OP_POP, POS_W'($urandom), pick_value(), $urandom);
        end
    endtask

    initial begin
        val_pool[0] = 32'sh7fffffff;
        val_pool[1] = 32'sh80000000;
        val_pool[2] = 32'sh0;
        val_pool[3] = -32'sd1;
        for (int i = 4; i < 16; i++) val_pool[i] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, bad positions, ends of the list, duplicates
        send_req(OP_POP,    11'd0,    32'sd0,          32'sd0);
        send_req(OP_FIND,   11'd0,    32'sd0,          32'sd0);
        send_req(OP_ALTER,  11'd0,    32'sd0,          32'sd7);
        send_req(OP_INSERT, 11'd0,    32'sd5,          32'sd0);
        send_req(OP_INSERT, 11'd2,    32'sd5,          32'sd0);
        send_req(OP_INSERT, 11'd1,    32'sh7fffffff,   32'sd0);
        send_req(OP_INSERT, 11'd1,    32'sh80000000,   32'sd0);
        send_req(OP_INSERT, 11'd3,    32'sd0,          32'sd0);
        send_req(OP_INSERT, 11'd2,    -32'sd1,         32'sd0);
        send_req(OP_INSERT, 11'd2047, 32'sd9,          32'sd0);
        send_req(OP_FIND,   11'd0,    32'sh80000000,   32'sd0);
        send_req(OP_FIND,   11'd0,    32'sd0,          32'sd0);
        send_req(OP_FIND,   11'd0,    32'sd12345,      32'sd0);
        send_req(OP_INSERT, 11'd4,    -32'sd1,         32'sd0);
        send_req(OP_FIND,   11'd0,    -32'sd1,         32'sd0);
        send_req(OP_ALTER,  11'd0,    -32'sd1,         32'sh7fffffff);
        send_req(OP_ALTER,  11'd0,    32'sd12345,      32'sd1);
        send_req(OP_FIND,   11'd0,    -32'sd1,         32'sd0);
        for (int i = 0; i < 6; i++) send_req(OP_POP, 11'h7ff, -32'sd1, -32'sd1);
        wait_results_drained();

        random_items(225);
        wait_results_drained();

        random_items(225);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("tb_ordered_list_engine passed");
        end else begin
            $display("tb_ordered_list_engine failed");
        end
        $finish;
    end

endmodule
